// File: hw/rtl/disparity_wta_subpixel_select_unit_assert.svh
// Assertion macros used by the checker file.
`ifndef DISPARITY_WTA_SUBPIXEL_SELECT_UNIT_ASSERT_SVH
`define DISPARITY_WTA_SUBPIXEL_SELECT_UNIT_ASSERT_SVH

// Same-cycle implication.
`define DWSS_ASSERT_NOW(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// Next-cycle implication.
`define DWSS_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

// File: hw/rtl/dwss_pkg.sv
package dwss_pkg;

   localparam int COST_W        = 8;
   localparam int CFG_W         = 9;
   localparam int DISP_W        = 14;
   localparam int CSR_IDX_W     = 2;
   localparam int MAX_RANGE_DEF = 256;
   localparam int FRAC_BITS_DEF = 4;
   localparam int RATIO_ONE     = 256;
   localparam int RATIO_SH      = 8;

   localparam logic [COST_W-1:0] COST_MAX = 8'd255;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_DISP,
      CSR_DISP_COUNT,
      CSR_CHECK_UNIQUE,
      CSR_UNIQ_RATIO
   } csr_index_type;

   // Pixel summary handed from the tracker to the refinement unit
   typedef struct packed {
      logic              bad;
      logic [COST_W-1:0] run_min;
      logic [COST_W-1:0] second_min;
      logic [COST_W-1:0] below;
      logic [COST_W-1:0] above;
   } pix_sum_type;

endpackage

// File: hw/rtl/dwss_track.sv
module dwss_track
   import dwss_pkg::*;
#(
   parameter int MAX_RANGE = MAX_RANGE_DEF,
   localparam int POS_W = $clog2(MAX_RANGE)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [COST_W-1:0] cost,
   input  logic [CFG_W-1:0]  disp_count,
   output logic              last,
   output logic              load,
   output pix_sum_type       sum,
   output logic [POS_W-1:0]  best_index
);

   localparam int CNT_W = $clog2(MAX_RANGE + 1);
   localparam int CW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;

   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [POS_W-1:0]  best_ff, best_in;
   logic [COST_W-1:0] min_ff, min_in;
   logic [COST_W-1:0] second_ff, second_in;
   logic [COST_W-1:0] prev_ff, prev_in;
   logic [COST_W-1:0] below_ff, below_in;
   logic [COST_W-1:0] above_ff, above_in;
   logic              found_ff, found_in;
   logic [CW-1:0]     count_eff;
   logic              above_hit;

   always_comb begin
      if (disp_count == '0) begin
         count_eff = CW'(1);
      end else if (CW'(disp_count) > CW'(MAX_RANGE)) begin
         count_eff = CW'(MAX_RANGE);
      end else begin
         count_eff = CW'(disp_count);
      end
      last = (CW'(pos_ff) + CW'(1)) >= count_eff;
      pos_in = last ? '0 : pos_ff + POS_W'(1);

      above_hit = found_ff &&
                  ((POS_W+1)'(pos_ff) == (POS_W+1)'(best_ff) + (POS_W+1)'(1));
      above_in  = above_hit ? cost : above_ff;
      min_in    = min_ff;
      second_in = second_ff;
      best_in   = best_ff;
      found_in  = found_ff;
      below_in  = below_ff;
      prev_in   = cost;
      if (cost < min_ff) begin
         second_in = (min_ff < second_ff) ? min_ff : second_ff;
         min_in    = cost;
         best_in   = pos_ff;
         found_in  = 1'b1;
         below_in  = (pos_ff != '0) ? prev_ff : '0;
      end else if (cost < second_ff) begin
         second_in = cost;
      end

      load           = accept && last;
      sum.bad        = !found_in || (best_in == '0) ||
                       ((CW'(best_in) + CW'(1)) >= count_eff);
      sum.run_min    = min_in;
      sum.second_min = second_in;
      sum.below      = below_in;
      sum.above      = above_in;
      best_index     = best_in;
   end

   always_ff @(posedge clock) begin
      if (reset || load) begin
         pos_ff    <= '0;
         best_ff   <= '0;
         min_ff    <= COST_MAX;
         second_ff <= COST_MAX;
         prev_ff   <= '0;
         below_ff  <= '0;
         above_ff  <= '0;
         found_ff  <= 1'b0;
      end else if (accept) begin
         pos_ff    <= pos_in;
         best_ff   <= best_in;
         min_ff    <= min_in;
         second_ff <= second_in;
         prev_ff   <= prev_in;
         below_ff  <= below_in;
         above_ff  <= above_in;
         found_ff  <= found_in;
      end
   end

endmodule

// File: hw/rtl/dwss_refine.sv
module dwss_refine
   import dwss_pkg::*;
#(
   parameter int MAX_RANGE = MAX_RANGE_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   localparam int POS_W = $clog2(MAX_RANGE)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  pix_sum_type       sum,
   input  logic [POS_W-1:0]  best_index,
   input  logic [CFG_W-1:0]  disp_base,
   input  logic              check_unique,
   input  logic [CFG_W-1:0]  ratio_q8,
   output logic              busy,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [DISP_W-1:0] out_disparity,
   output logic              out_valid_res
);

   localparam int NUM_W  = COST_W + FRAC_BITS + 1;
   localparam int DEN_W  = COST_W + 1;
   localparam int DIV_W  = COST_W + 2;
   localparam int PROD_W = COST_W + CFG_W;
   localparam int STEP_W = $clog2(NUM_W);
   localparam int DA_W   = ((POS_W + 1) > CFG_W) ? (POS_W + 1) : CFG_W;
   localparam int D_W    = DA_W + 1;
   localparam int TA_W   = ((D_W + FRAC_BITS) > NUM_W) ? (D_W + FRAC_BITS) : NUM_W;
   localparam int TB_W   = (TA_W > DISP_W) ? TA_W : DISP_W;
   localparam int T_W    = TB_W + 2;
   localparam logic signed [T_W-1:0] SAT_HI = T_W'(2 ** (DISP_W - 1) - 1);
   localparam logic signed [T_W-1:0] SAT_LO = T_W'(-(2 ** (DISP_W - 1)));

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_type;

   state_type         state_ff;
   logic [STEP_W-1:0] step_ff;
   logic [NUM_W-1:0]  quo_ff, quo_in;
   logic [DIV_W-1:0]  rem_ff, rem_in;
   logic [DIV_W-1:0]  div_ff;
   logic [PROD_W-1:0] acc_ff, acc_in;
   logic [PROD_W-1:0] mcand_ff;
   logic [CFG_W-1:0]  mplier_ff;
   logic [COST_W-1:0] udiff_ff;
   logic [POS_W-1:0]  best_ff;
   logic              bad_ff;
   logic              neg_ff;
   logic              out_valid_ff;
   logic [DISP_W-1:0] out_disp_ff;
   logic              out_vres_ff;

   logic [COST_W:0]        diff_c;
   logic                   neg_c;
   logic [COST_W-1:0]      mag_c;
   logic signed [DIV_W-1:0] den_raw;
   logic [DEN_W-1:0]       den_c;
   logic [NUM_W-1:0]       numer_c;
   logic [CFG_W-1:0]       ratio_sat;
   logic [CFG_W-1:0]       k_c;
   logic [DIV_W:0]         trial;
   logic [DIV_W:0]         trial_sub;
   logic                   trial_ge;
   logic signed [D_W-1:0]  d_val;
   logic signed [T_W-1:0]  q_ext;
   logic signed [T_W-1:0]  total;
   logic [DISP_W-1:0]      disp_c;
   logic                   uniq_bad;
   logic                   vres_c;

   always_comb begin
      diff_c  = {1'b0, sum.below} - {1'b0, sum.above};
      neg_c   = diff_c[COST_W];
      mag_c   = neg_c ? COST_W'(-diff_c) : diff_c[COST_W-1:0];
      den_raw = $signed({2'b00, sum.below} + {2'b00, sum.above} -
                        {1'b0, sum.run_min, 1'b0});
      den_c   = (den_raw[DIV_W-1] || (den_raw == '0)) ? DEN_W'(1)
                                                       : den_raw[DEN_W-1:0];
      numer_c = NUM_W'({mag_c, {FRAC_BITS{1'b0}}}) + NUM_W'(den_c);
      ratio_sat = (ratio_q8 > CFG_W'(RATIO_ONE)) ? CFG_W'(RATIO_ONE) : ratio_q8;
      k_c       = CFG_W'(RATIO_ONE) - ratio_sat;

      trial     = {rem_ff, quo_ff[NUM_W-1]};
      trial_sub = trial - {1'b0, div_ff};
      trial_ge  = trial >= {1'b0, div_ff};
      rem_in    = trial_ge ? trial_sub[DIV_W-1:0] : trial[DIV_W-1:0];
      quo_in    = {quo_ff[NUM_W-2:0], trial_ge};
      acc_in    = mplier_ff[0] ? acc_ff + mcand_ff : acc_ff;

      d_val = D_W'($signed(disp_base)) + D_W'($signed({1'b0, best_ff}));
      q_ext = T_W'({1'b0, quo_ff});
      total = (T_W'(d_val) <<< FRAC_BITS) + (neg_ff ? -q_ext : q_ext);
      if (total > SAT_HI) begin
         disp_c = SAT_HI[DISP_W-1:0];
      end else if (total < SAT_LO) begin
         disp_c = SAT_LO[DISP_W-1:0];
      end else begin
         disp_c = total[DISP_W-1:0];
      end
      uniq_bad = check_unique &&
                 ({1'b0, udiff_ff} <= acc_ff[PROD_W-1:RATIO_SH]);
      vres_c   = !bad_ff && !uniq_bad;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (out_valid_ff && out_ready && (state_ff != ST_DONE)) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (load) begin
                  quo_ff    <= numer_c;
                  rem_ff    <= '0;
                  div_ff    <= {den_c, 1'b0};
                  acc_ff    <= '0;
                  mcand_ff  <= PROD_W'(sum.run_min);
                  mplier_ff <= k_c;
                  udiff_ff  <= sum.second_min - sum.run_min;
                  best_ff   <= best_index;
                  bad_ff    <= sum.bad;
                  neg_ff    <= neg_c;
                  step_ff   <= '0;
                  state_ff  <= ST_RUN;
               end
            end
            ST_RUN: begin
               quo_ff    <= quo_in;
               rem_ff    <= rem_in;
               acc_ff    <= acc_in;
               mcand_ff  <= {mcand_ff[PROD_W-2:0], 1'b0};
               mplier_ff <= {1'b0, mplier_ff[CFG_W-1:1]};
               step_ff   <= step_ff + STEP_W'(1);
               if (step_ff == STEP_W'(NUM_W - 1)) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (!out_valid_ff || out_ready) begin
                  out_valid_ff <= 1'b1;
                  out_disp_ff  <= vres_c ? disp_c : '0;
                  out_vres_ff  <= vres_c;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy          = (state_ff != ST_IDLE);
   assign out_valid     = out_valid_ff;
   assign out_disparity = out_disp_ff;
   assign out_valid_res = out_vres_ff;

endmodule

// File: hw/rtl/disparity_wta_subpixel_select_unit.sv
// Winner-take-all disparity select with parabola sub-pixel refinement.
// req_ channel: one aggregated cost word per cycle, in rising disparity
// order, disp_count words per pixel. rsp_ channel: one word per pixel,
// the disparity in signed fixed point with FRAC_BITS fraction bits and a
// valid flag; an invalid word carries disparity 0.
// csr_ port: write the disparity base, disp_count, check_unique and
// uniqueness_ratio_q8 by index while the block is idle.
// Costs are tracked at one word per cycle. After the last cost of a pixel
// is accepted, a bit-serial divider and shift-add multiplier run in the
// RUN state; the DONE state then loads the result word into the output
// register. The last cost of the next pixel waits while the divider is
// busy, earlier costs do not. Reset clears the pixel tracker and the
// result valid flag, returns the divider to idle and restores the
// register defaults. When the receiver stalls, the result word is held
// and costs keep flowing until a further result is ready.
module disparity_wta_subpixel_select_unit
   import dwss_pkg::*;
#(
   parameter int MAX_RANGE = MAX_RANGE_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [COST_W-1:0]    req_cost,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [DISP_W-1:0]    rsp_disparity_q4,
   output logic                 rsp_valid_res,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   localparam int POS_W = $clog2(MAX_RANGE);

   logic [CFG_W-1:0] min_disp_ff;
   logic [CFG_W-1:0] disp_count_ff;
   logic             check_unique_ff;
   logic [CFG_W-1:0] ratio_ff;

   logic             accept;
   logic             last;
   logic             load;
   logic             busy;
   pix_sum_type      sum;
   logic [POS_W-1:0] best_index;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_disp_ff     <= '0;
         disp_count_ff   <= CFG_W'(64);
         check_unique_ff <= 1'b0;
         ratio_ff        <= CFG_W'(243);
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_MIN_DISP:     min_disp_ff     <= csr_wdata;
            CSR_DISP_COUNT:   disp_count_ff   <= csr_wdata;
            CSR_CHECK_UNIQUE: check_unique_ff <= csr_wdata[0];
            CSR_UNIQ_RATIO:   ratio_ff        <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // hold the last word of a pixel while the divider is busy
   assign req_ready = !busy || !last;
   assign accept    = req_valid && req_ready;

   dwss_track #(
      .MAX_RANGE (MAX_RANGE)
   ) u_track (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .cost       (req_cost),
      .disp_count (disp_count_ff),
      .last       (last),
      .load       (load),
      .sum        (sum),
      .best_index (best_index)
   );

   dwss_refine #(
      .MAX_RANGE (MAX_RANGE),
      .FRAC_BITS (FRAC_BITS)
   ) u_refine (
      .clock         (clock),
      .reset         (reset),
      .load          (load),
      .sum           (sum),
      .best_index    (best_index),
      .disp_base     (min_disp_ff),
      .check_unique  (check_unique_ff),
      .ratio_q8      (ratio_ff),
      .busy          (busy),
      .out_valid     (rsp_valid),
      .out_ready     (rsp_ready),
      .out_disparity (rsp_disparity_q4),
      .out_valid_res (rsp_valid_res)
   );

endmodule

// File: hw/rtl/dwss_checker.sv
`include "disparity_wta_subpixel_select_unit_assert.svh"

module dwss_checker
   import dwss_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [DISP_W-1:0] rsp_disparity_q4,
   input logic              rsp_valid_res
);

   `DWSS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_disparity_q4) && $stable(rsp_valid_res),
      "stalled result word changed")

   `DWSS_ASSERT_NOW(a_invalid_zero, clock, reset, rsp_valid && !rsp_valid_res,
      rsp_disparity_q4 == '0, "invalid result word carries a non-zero disparity")

   `DWSS_ASSERT_NEXT(a_reset_rsp, clock, 1'b0, reset, !rsp_valid,
      "result word valid after reset")

   `DWSS_ASSERT_NEXT(a_reset_ready, clock, 1'b0, reset, req_ready,
      "cost channel not ready after reset")

endmodule

bind disparity_wta_subpixel_select_unit dwss_checker u_checker (.*);
